// ===== rtl/core/strm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package strm_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FILL  = 7'b0000010,
		ST_RD_A  = 7'b0000100,
		ST_RD_B  = 7'b0001000,
		ST_VAL_A = 7'b0010000,
		ST_VAL_B = 7'b0100000,
		ST_CMP   = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/sparse_table_range_min.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Range-minimum engine built on a sparse table. The values sit in one
// synchronous memory and the doubling table in a second one; both have
// registered reads. Only one item is in work at a time, and the input
// stalls while it runs or while a result waits in the output register.
// A load transfer writes one value. A query whose range is bad, reversed or
// a single element loads the result register straight from the decode. Any
// other query runs two table reads, two value reads through the single
// value port, then the compare that loads the result register. A build
// transfer first writes level 0 (one entry per cycle), then fills every
// higher level entry by entry (two table reads, two value reads, compare and
// write). Accesses never overlap on one entry because a level reads only the
// level below it and items do not run concurrently. A query may only touch
// entries that were loaded and built before; other entries read as whatever
// the memory holds.
module sparse_table_range_min #(
	parameter int unsigned MAX_ELEMENTS = 1024,
	parameter int unsigned VALUE_WIDTH  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [9:0]  position,
	input  wire logic [9:0]  range_end,
	input  wire logic [63:0] value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [9:0]       min_index,
	output logic             range_error
);
	localparam int unsigned AW     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned CW     = AW + 1;
	localparam int unsigned LEV    = AW + 1;
	localparam int unsigned LW     = $clog2(LEV);
	localparam int unsigned TDEPTH = LEV * MAX_ELEMENTS;
	localparam int unsigned TW     = $clog2(TDEPTH);

	// Table entry of a level and a position; levels are stacked one above
	// the other.
	function automatic logic [TW-1:0] taddr(input logic [LW-1:0] lev, input logic [AW-1:0] idx);
		return TW'(lev) * TW'(MAX_ELEMENTS) + TW'(idx);
	endfunction

	logic [VALUE_WIDTH-1:0] vmem [MAX_ELEMENTS];
	logic [AW-1:0]          tmem [TDEPTH];

	strm_pkg::state_t state_q;
	logic [10:0]      count_q;
	logic [CW-1:0]    n_eff;

	// Working registers. In a build lev_q is the level being read, and the
	// level above it is written.
	logic                   bld_q;
	logic [AW-1:0]          i_q, a_q, b_q;
	logic [LW-1:0]          lev_q;
	logic [VALUE_WIDTH-1:0] va_q;

	// Memory ports.
	logic                   v_we, t_we;
	logic [AW-1:0]          v_waddr, v_raddr;
	logic [VALUE_WIDTH-1:0] v_wdata, v_rdata_s1;
	logic [TW-1:0]          t_waddr, t_raddr;
	logic [AW-1:0]          t_wdata, t_rdata_s1;

	always_ff @(posedge clk) begin
		if (v_we) vmem[v_waddr] <= v_wdata;
		v_rdata_s1 <= vmem[v_raddr];
	end
	always_ff @(posedge clk) begin
		if (t_we) tmem[t_waddr] <= t_wdata;
		t_rdata_s1 <= tmem[t_raddr];
	end

	// The count in use saturates at the table size.
	always_comb begin
		if (32'(count_q) > MAX_ELEMENTS) n_eff = CW'(MAX_ELEMENTS);
		else n_eff = CW'(count_q);
	end

	// Query decode: the level is the highest set bit of the range length, and
	// the right span starts so that it ends at the range end.
	logic [10:0]   q_len;
	logic [LW-1:0] q_lev;
	logic [10:0]   q_right;
	logic          q_bad;
	always_comb begin
		q_len = 11'(range_end) - 11'(position) + 11'd1;
		q_lev = '0;
		for (int k = 0; k < 11; k++) if (q_len[k]) q_lev = LW'(k);
		q_right = 11'(range_end) + 11'd1 - (11'd1 << q_lev);
		q_bad = (32'(range_end) >= 32'(n_eff)) || (position > range_end);
	end

	// Highest table level that a build fills: one less than the bit width of
	// the count.
	logic [LW-1:0] lev_last;
	always_comb begin
		lev_last = '0;
		for (int k = 0; k < CW; k++) if (n_eff[k]) lev_last = LW'(k);
	end

	logic          accept;
	logic          op_load, op_build, op_query;
	logic          res_load;
	logic [9:0]    res_idx;
	logic          res_err;
	logic [CW-1:0] r_pos;
	logic [AW-1:0] last_i;
	logic          pick_b;
	logic [AW-1:0] winner;

	assign in_stall = (state_q != strm_pkg::ST_IDLE) || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;
	assign op_load  = accept && (opcode == strm_pkg::OP_LOAD);
	assign op_build = accept && (opcode == strm_pkg::OP_BUILD);
	assign op_query = accept && (opcode == strm_pkg::OP_QUERY);
	assign last_i   = AW'(n_eff - CW'(1));
	// Ties go to the left-hand position.
	assign pick_b   = v_rdata_s1 < va_q;
	assign winner   = pick_b ? b_q : a_q;

	// Right-hand position of a build step, clamped to the last entry in use.
	always_comb begin
		r_pos = CW'(i_q) + (CW'(1) << lev_q);
		if (r_pos > CW'(last_i)) r_pos = CW'(last_i);
	end

	always_comb begin
		v_we    = op_load && (32'(position) < MAX_ELEMENTS);
		v_waddr = AW'(position);
		v_wdata = value[VALUE_WIDTH-1:0];
		v_raddr = a_q;
		t_we    = 1'b0;
		t_waddr = taddr(lev_q + LW'(1), i_q);
		t_wdata = winner;
		t_raddr = taddr(lev_q, bld_q ? i_q : a_q);
		unique case (state_q)
			strm_pkg::ST_IDLE: ;
			strm_pkg::ST_FILL: begin
				t_we    = 1'b1;
				t_waddr = taddr(LW'(0), i_q);
				t_wdata = i_q;
			end
			strm_pkg::ST_RD_A: ;
			strm_pkg::ST_RD_B: t_raddr = taddr(lev_q, bld_q ? AW'(r_pos) : b_q);
			strm_pkg::ST_VAL_A: v_raddr = a_q;
			strm_pkg::ST_VAL_B: v_raddr = b_q;
			strm_pkg::ST_CMP: t_we = bld_q;
			default: ;
		endcase
	end

	// A result is loaded either straight from the decode or from the compare.
	always_comb begin
		res_load = 1'b0;
		res_idx  = '0;
		res_err  = 1'b0;
		if (op_query && (q_bad || position == range_end)) begin
			res_load = 1'b1;
			res_err  = q_bad;
			res_idx  = q_bad ? 10'd0 : position;
		end else if (state_q == strm_pkg::ST_CMP && !bld_q) begin
			res_load = 1'b1;
			res_idx  = 10'(winner);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= strm_pkg::ST_IDLE;
			count_q     <= 11'd1;
			bld_q       <= 1'b0;
			lev_q       <= '0;
			i_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			va_q        <= '0;
			out_valid   <= 1'b0;
			min_index   <= '0;
			range_error <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (res_load) begin
				out_valid   <= 1'b1;
				min_index   <= res_idx;
				range_error <= res_err;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				strm_pkg::ST_IDLE: begin
					if (op_build && n_eff != '0) begin
						bld_q   <= 1'b1;
						i_q     <= '0;
						state_q <= strm_pkg::ST_FILL;
					end else if (op_query && !q_bad && position != range_end) begin
						bld_q   <= 1'b0;
						a_q     <= AW'(position);
						b_q     <= AW'(q_right);
						lev_q   <= q_lev;
						state_q <= strm_pkg::ST_RD_A;
					end
				end
				strm_pkg::ST_FILL: begin
					if (i_q == last_i) begin
						i_q   <= '0;
						lev_q <= '0;
						if (lev_last == '0) state_q <= strm_pkg::ST_IDLE;
						else state_q <= strm_pkg::ST_RD_A;
					end else begin
						i_q <= i_q + AW'(1);
					end
				end
				strm_pkg::ST_RD_A: state_q <= strm_pkg::ST_RD_B;
				strm_pkg::ST_RD_B: begin
					a_q     <= t_rdata_s1;
					state_q <= strm_pkg::ST_VAL_A;
				end
				strm_pkg::ST_VAL_A: begin
					b_q     <= t_rdata_s1;
					state_q <= strm_pkg::ST_VAL_B;
				end
				strm_pkg::ST_VAL_B: begin
					va_q    <= v_rdata_s1;
					state_q <= strm_pkg::ST_CMP;
				end
				strm_pkg::ST_CMP: begin
					if (!bld_q) begin
						state_q <= strm_pkg::ST_IDLE;
					end else if (i_q != last_i) begin
						i_q     <= i_q + AW'(1);
						state_q <= strm_pkg::ST_RD_A;
					end else begin
						i_q <= '0;
						if (lev_q + LW'(1) == lev_last) begin
							state_q <= strm_pkg::ST_IDLE;
						end else begin
							lev_q   <= lev_q + LW'(1);
							state_q <= strm_pkg::ST_RD_A;
						end
					end
				end
				default: state_q <= strm_pkg::ST_IDLE;
			endcase
		end
	end

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != strm_pkg::ST_IDLE) |-> in_stall) else $error("stall low while busy");
	a_err_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (min_index == 10'd0)) else $error("error with index");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(min_index) && $stable(range_error)))
		else $error("result dropped or changed");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(out_valid && out_stall)) else $error("waiting result overwritten");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	// One input transfer as the driver presents it.
	typedef struct {
		strm_pkg::opcode_t op;
		logic [9:0]        pos;
		logic [9:0]        rend;
		logic [63:0]       val;
	} rmq_item_t;

	// One query answer as the block should return it.
	typedef struct {
		logic [9:0] idx;
		logic       err;
	} rmq_answer_t;

	localparam int unsigned MAX_N  = 1024;
	localparam int unsigned LEVELS = 11;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [9:0]  position;
	logic [9:0]  range_end;
	logic [63:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [9:0]  min_index;
	logic        range_error;

	sparse_table_range_min i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.position   (position),
		.range_end  (range_end),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.min_index  (min_index),
		.range_error(range_error)
	);

	// Pending input transfers and the answers still owed by the block.
	rmq_item_t   pending_items[$];
	rmq_answer_t owed_answers[$];
	int          mismatch_count = 0;

	// Idle rates in percent for each side, and the long receiver hold-off.
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_req = 1'b0;
	int   hold_left = 0;

	// Shadow copy of the block's state, kept by the predictor below.
	logic [63:0] shadow_values[MAX_N];
	logic [9:0]  shadow_table[MAX_N][LEVELS];
	logic [10:0] shadow_count = 11'd1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned span_bits(int unsigned x);
		int unsigned w;
		w = 0;
		while (x != 0) begin
			w++;
			x >>= 1;
		end
		return w;
	endfunction

	function automatic int unsigned live_count();
		return (shadow_count > MAX_N) ? MAX_N : shadow_count;
	endfunction

	// Leftmost of two positions on a tie.
	function automatic logic [9:0] smaller_pos(logic [9:0] a, logic [9:0] b);
		return (shadow_values[a] <= shadow_values[b]) ? a : b;
	endfunction

	function automatic void rebuild_table();
		int unsigned n;
		int unsigned lv;
		int unsigned r;
		n = live_count();
		lv = span_bits(n);
		for (int unsigned i = 0; i < n; i++)
			shadow_table[i][0] = i[9:0];
		for (int unsigned j = 1; j < lv; j++) begin
			for (int unsigned i = 0; i < n; i++) begin
				r = i + (1 << (j - 1));
				if (r > n - 1)
					r = n - 1;
				shadow_table[i][j] = smaller_pos(shadow_table[i][j-1], shadow_table[r][j-1]);
			end
		end
	endfunction

	// Applies one accepted transfer to the shadow state and queues the answer
	// that a query owes.
	function automatic void apply_item(rmq_item_t it);
		rmq_answer_t a;
		int unsigned n;
		int unsigned len;
		int unsigned lv;
		case (it.op)
			strm_pkg::OP_LOAD: shadow_values[it.pos] = it.val;
			strm_pkg::OP_BUILD: rebuild_table();
			strm_pkg::OP_QUERY: begin
				n = live_count();
				a.idx = '0;
				a.err = 1'b0;
				if (it.rend >= n || it.pos > it.rend) begin
					a.err = 1'b1;
				end else if (it.pos == it.rend) begin
					a.idx = it.pos;
				end else begin
					len = it.rend - it.pos + 1;
					lv = span_bits(len) - 1;
					a.idx = smaller_pos(shadow_table[it.pos][lv],
						shadow_table[it.rend + 1 - (1 << lv)][lv]);
				end
				owed_answers.insert(owed_answers.size(), a);
			end
			default: ;
		endcase
	endfunction

	// Driver: predicts each accepted transfer, then offers the next one unless
	// it decides to idle.
	always @(posedge clk or negedge arst_n) begin
		rmq_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= strm_pkg::OP_NONE;
			position <= '0;
			range_end <= '0;
			value <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				it.op = strm_pkg::opcode_t'(opcode);
				it.pos = position;
				it.rend = range_end;
				it.val = value;
				apply_item(it);
			end
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				opcode <= it.op;
				position <= it.pos;
				range_end <= it.rend;
				value <= it.val;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall. A hold-off request keeps the output stalled for a long
	// stretch so that the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (hold_req)
				hold_left <= 400;
			else if (hold_left > 0)
				hold_left <= hold_left - 1;
			out_stall <= hold_req || hold_left > 1 || $urandom_range(99) < recv_idle_pct;
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Monitor: every accepted result transfer is checked against the oldest
	// owed answer.
	always @(posedge clk) begin
		rmq_answer_t a;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_answers.size() == 0) begin
				report_mismatch("unexpected result, min_index", min_index, -1);
			end else begin
				a = owed_answers.pop_front();
				if (range_error !== a.err)
					report_mismatch("range_error", range_error, a.err);
				if (min_index !== a.idx)
					report_mismatch("min_index", min_index, a.idx);
			end
		end
	end

	task automatic push_item(strm_pkg::opcode_t op, int p, int e, logic [63:0] v);
		rmq_item_t it;
		it.op = op;
		it.pos = p[9:0];
		it.rend = e[9:0];
		it.val = v;
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic logic [63:0] rand_value();
		// Small values half of the time so that ties are common.
		if ($urandom_range(1))
			return 64'($urandom_range(3));
		return {$urandom(), $urandom()};
	endfunction

	// Waits until the block has drained: nothing left to send, nothing owed
	// and the input no longer stalled, seen on several edges in a row so that
	// a build still in work is not missed.
	task automatic wait_quiet();
		int quiet;
		quiet = 0;
		while (quiet < 3) begin
			@(posedge clk);
			if (pending_items.size() == 0 && !in_valid && !in_stall
				&& owed_answers.size() == 0)
				quiet++;
			else
				quiet = 0;
		end
	endtask

	task automatic write_count(int unsigned c);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= c[10:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_count = c[10:0];
	endtask

	// One phase: set the count, load every value in use, build, then a mix of
	// mostly well-formed queries with loads, rebuilds and broken items.
	task automatic run_phase(int unsigned cnt, int unsigned extra);
		int unsigned n;
		int unsigned s;
		int unsigned roll;
		write_count(cnt);
		n = (cnt > MAX_N) ? MAX_N : cnt;
		for (int unsigned i = 0; i < n; i++)
			push_item(strm_pkg::OP_LOAD, i, $urandom_range(1023), rand_value());
		push_item(strm_pkg::OP_BUILD, $urandom_range(1023), $urandom_range(1023), rand_value());
		for (int unsigned k = 0; k < extra; k++) begin
			roll = $urandom_range(99);
			s = $urandom_range(n - 1);
			if (roll < 70)
				push_item(strm_pkg::OP_QUERY, s, $urandom_range(n - 1, s), '0);
			else if (roll < 80)
				push_item(strm_pkg::OP_LOAD, $urandom_range(1023), $urandom_range(1023),
					rand_value());
			else if (roll < 85)
				push_item(strm_pkg::OP_BUILD, $urandom_range(1023), $urandom_range(1023),
					rand_value());
			else if (roll < 90 && n < MAX_N)
				push_item(strm_pkg::OP_QUERY, $urandom_range(1023), $urandom_range(1023, n), '0);
			else if (roll < 97)
				push_item(strm_pkg::OP_QUERY, $urandom_range(1023, s + 1), s, '0);
			else
				push_item(strm_pkg::OP_NONE, $urandom_range(1023), $urandom_range(1023),
					rand_value());
		end
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset count of one and then at a count of two:
		// extreme values and positions, a single-element range, bad and reversed
		// ranges, the unused opcode, and a tie that must go to the left.
		send_idle_pct = 10;
		recv_idle_pct = 85;
		push_item(strm_pkg::OP_LOAD, 0, 0, '1);
		push_item(strm_pkg::OP_LOAD, 1023, 1023, '1);
		push_item(strm_pkg::OP_LOAD, 1, 0, '0);
		push_item(strm_pkg::OP_BUILD, 0, 0, '0);
		push_item(strm_pkg::OP_QUERY, 0, 0, '0);
		push_item(strm_pkg::OP_QUERY, 0, 1, '0);
		push_item(strm_pkg::OP_QUERY, 1, 0, '0);
		push_item(strm_pkg::OP_QUERY, 1023, 1023, '0);
		push_item(strm_pkg::OP_QUERY, 0, 1023, '0);
		push_item(strm_pkg::OP_NONE, 1023, 1023, '1);
		write_count(2);
		push_item(strm_pkg::OP_LOAD, 1, 0, '1);
		push_item(strm_pkg::OP_BUILD, 0, 0, '0);
		push_item(strm_pkg::OP_QUERY, 0, 1, '0);
		push_item(strm_pkg::OP_QUERY, 1, 1, '0);
		push_item(strm_pkg::OP_QUERY, 1, 0, '0);
		push_item(strm_pkg::OP_QUERY, 0, 2, '0);
		// A count of zero makes a build do nothing and every query an error.
		write_count(0);
		push_item(strm_pkg::OP_BUILD, 0, 0, '0);
		push_item(strm_pkg::OP_QUERY, 0, 0, '0);
		push_item(strm_pkg::OP_QUERY, 5, 3, '0);

		// Random phases with small counts, first one idle pattern, then the
		// other, then none at all.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				wait_quiet();
				send_idle_pct = 85;
				recv_idle_pct = 10;
			end else if (ph == 8) begin
				wait_quiet();
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			run_phase((ph == 3) ? 1 : $urandom_range(48, 2), 40);
			if (ph == 9) begin
				// Hold the output off once queries are flowing.
				while (owed_answers.size() == 0)
					@(posedge clk);
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
		end

		// Largest count, written above the table size so that it saturates.
		run_phase(2047, 60);
		wait_quiet();
		push_item(strm_pkg::OP_QUERY, 0, 1023, '0);
		push_item(strm_pkg::OP_QUERY, 1023, 1023, '0);
		run_phase(1, 10);

		wait_quiet();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && owed_answers.size() == 0)
			$display("sparse_table_range_min regression: pass");
		else
			$display("sparse_table_range_min regression: fail");
		$finish;
	end

	initial begin
		#40ms;
		$display("sparse_table_range_min regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
